// ===== design/pcm_mix_pkg.sv =====
// Shared constants, types and codes of the multi-voice PCM mixer.
package pcm_mix_pkg;

  // Voice table depth and sample memory depth (a power of two).
  localparam int VOICE_COUNT  = 16;
  localparam int SAMPLE_DEPTH = 65536;

  // Widths fixed by the word fields.
  localparam int ADDR_IN_W = 16;
  localparam int LEN_W     = 17;
  localparam int GAIN_W    = 8;
  localparam int BYTE_W    = 8;
  localparam int MASK_W    = 16;

  // Derived widths.
  localparam int VIDX_W  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int VCNT_W  = $clog2(VOICE_COUNT + 1);
  localparam int SADDR_W = $clog2(SAMPLE_DEPTH);
  localparam int SUM_W   = ((SADDR_W > LEN_W) ? SADDR_W : LEN_W) + 1;
  localparam int PROD_W  = 17;
  localparam int ACC_W   = BYTE_W + VCNT_W;

  // One entry of the voice table.
  typedef struct packed {
    logic [ADDR_IN_W-1:0] base;
    logic [LEN_W-1:0]     vend;
    logic [LEN_W-1:0]     pos;
    logic [GAIN_W-1:0]    gain;
  } voice_entry_t;

  localparam int VENT_W = $bits(voice_entry_t);

  // Item modes.
  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_MIX   = 2'd2,
    MODE_STOP  = 2'd3
  } mode_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_DONE
  } state_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic              clr;
    logic              act;
    logic [GAIN_W-1:0] gain;
  } mac_ctl_t;

endpackage

// ===== design/pcm_mix_if.sv =====
// Valid/ready channel interfaces for the mixer's input and result words.
interface pcm_mix_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [3:0]  voice_id;
  logic [15:0] sample_address;
  logic [7:0]  sample_byte;
  logic [16:0] voice_length;
  logic [7:0]  voice_volume;

  modport source (
    output valid, mode, voice_id, sample_address, sample_byte, voice_length,
           voice_volume,
    input  ready
  );
  modport sink (
    input  valid, mode, voice_id, sample_address, sample_byte, voice_length,
           voice_volume,
    output ready
  );
endinterface

interface pcm_mix_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  mix_sample;
  logic        start_accepted;
  logic [15:0] active_mask;

  modport source (
    output valid, mix_sample, start_accepted, active_mask,
    input  ready
  );
  modport sink (
    input  valid, mix_sample, start_accepted, active_mask,
    output ready
  );
endinterface

// ===== design/pcm_mix_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module pcm_mix_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/pcm_mix_acc.sv =====
// Scale, divide by 255 and accumulate unit of the mixer, with output clamp.
module pcm_mix_acc (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pcm_mix_pkg::mac_ctl_t         ctl,
  input  logic [pcm_mix_pkg::BYTE_W-1:0] smp,
  output logic [pcm_mix_pkg::BYTE_W-1:0] mix,
  output logic                          pend
);
  import pcm_mix_pkg::*;

  logic                     s3_act_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [PROD_W-1:0] sdiff;
  logic signed [PROD_W-1:0] gain_x;
  logic [PROD_W-1:0]        mag;
  logic [BYTE_W-1:0]        quo;
  logic signed [ACC_W-1:0]  quo_s;
  logic signed [ACC_W-1:0]  acc_off;

  // Floor of m / 255 for m below 32768, by the reciprocal 257 / 65536.
  function automatic logic [BYTE_W-1:0] div255(input logic [14:0] m);
    logic [15:0] t;
    t = 16'(m) + 16'(m >> 8) + 16'd1;
    return t[15:8];
  endfunction

  // Centered sample times gain.
  always_comb begin
    sdiff    = PROD_W'($signed({1'b0, smp})) - PROD_W'(128);
    gain_x   = $signed(PROD_W'(ctl.gain));
    prod_nxt = sdiff * gain_x;
  end

  // Divide the product by 255, truncating toward zero, and accumulate.
  always_comb begin
    mag   = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
    quo   = div255(mag[14:0]);
    quo_s = prod_r[PROD_W-1] ? -$signed(ACC_W'(quo)) : $signed(ACC_W'(quo));
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (s3_act_r) begin
      acc_nxt = acc_r + quo_s;
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_act_r <= 1'b0;
    end else begin
      s3_act_r <= ctl.act;
    end
    if (ctl.act) begin
      prod_r <= prod_nxt;
    end
    acc_r <= acc_nxt;
  end

  // Clamp to -128..127 and offset by 128.
  always_comb begin
    acc_off = acc_r + ACC_W'(128);
    if (acc_r > ACC_W'(127)) begin
      mix = 8'hFF;
    end else if (acc_r < -ACC_W'(128)) begin
      mix = 8'h00;
    end else begin
      mix = acc_off[BYTE_W-1:0];
    end
  end

  assign pend = ctl.act || s3_act_r;

endmodule

// ===== design/multi_voice_pcm_mixer.sv =====
// Top level of the multi-voice PCM mixer: sequencer, voice table and sample memory.
//
//   channel   direction  handshake      word
//   in_word   sink       valid/ready    mode, slot, address, byte, length, volume
//   out_word  source     valid/ready    mix_sample, start_accepted, active_mask
//
// A load, start or stop word passes through the done state to the output register; a mix
// word first drains the voice pipeline, as the voice table read port walks one voice
// per cycle ahead of the sample read, multiply and accumulate stages.
// The input takes a new word only once the last result has entered the output register.
// Reset clears playing bits, sequencer and output valid only; memories need no clearing.
// One result may wait in the output register; the next holds the input off until it drains.
module multi_voice_pcm_mixer (
  input logic           clk,
  input logic           rst_n,
  pcm_mix_in_if.sink    in_word,
  pcm_mix_out_if.source out_word
);
  import pcm_mix_pkg::*;

  state_t                 state_r, state_nxt;
  logic [VOICE_COUNT-1:0] playing_r, playing_nxt;
  logic [VCNT_W-1:0]      iss_cnt_r, iss_cnt_nxt;
  logic                   s1_vld_r, s1_vld_nxt;
  logic [VIDX_W-1:0]      s1_idx_r, s1_idx_nxt;
  logic                   s2_act_r, s2_act_nxt;
  logic [GAIN_W-1:0]      s2_gain_r, s2_gain_nxt;
  logic [BYTE_W-1:0]      res_smp_r, res_smp_nxt;
  logic                   res_acc_r, res_acc_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]      out_smp_r, out_smp_nxt;
  logic                   out_acc_r, out_acc_nxt;
  logic [MASK_W-1:0]      out_mask_r, out_mask_nxt;

  logic                   in_acc;
  mode_t                  in_mode;
  logic [VIDX_W-1:0]      start_idx;
  logic                   start_ok;
  logic                   iss_done;
  logic                   drained;
  logic                   out_free;
  logic                   s1_act;
  logic [LEN_W-1:0]       pos_inc;

  logic                   v_we;
  logic [VIDX_W-1:0]      v_waddr;
  voice_entry_t           v_wdata;
  logic [VIDX_W-1:0]      v_raddr;
  logic [VENT_W-1:0]      v_rdata;
  voice_entry_t           v_ent;

  logic                   s_we;
  logic [SADDR_W-1:0]     s_waddr;
  logic [SADDR_W-1:0]     s_raddr;
  logic [BYTE_W-1:0]      s_rdata;

  mac_ctl_t               mac_ctl;
  logic [BYTE_W-1:0]      mac_mix;
  logic                   mac_pend;

  // Voice table: base, end, position and gain of each voice.
  pcm_mix_ram #(.WIDTH(VENT_W), .DEPTH(VOICE_COUNT)) u_voice_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  // Sample memory.
  pcm_mix_ram #(.WIDTH(BYTE_W), .DEPTH(SAMPLE_DEPTH)) u_sample_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (in_word.sample_byte),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // Multiply, divide and accumulate stages.
  pcm_mix_acc u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .smp   (s_rdata),
    .mix   (mac_mix),
    .pend  (mac_pend)
  );

  // Handshake and common decodes.
  assign in_word.ready = (state_r == ST_IDLE);
  assign in_acc        = in_word.valid && in_word.ready;
  assign in_mode       = mode_t'(in_word.mode);
  assign start_idx     = VIDX_W'(in_word.voice_id);
  assign start_ok      = (32'(in_word.voice_id) < VOICE_COUNT) &&
                         (in_word.voice_length != '0) && !playing_r[start_idx];
  assign iss_done      = (iss_cnt_r == VCNT_W'(VOICE_COUNT));
  assign drained       = iss_done && !s1_vld_r && !s2_act_r && !mac_pend;
  assign out_free      = !out_valid_r || out_word.ready;
  assign v_ent         = voice_entry_t'(v_rdata);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_mode == MODE_MIX) ? ST_MIX : ST_DONE;
        end
      end
      ST_MIX: begin
        if (drained) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    playing_nxt  = playing_r;
    iss_cnt_nxt  = iss_cnt_r;
    s1_vld_nxt   = 1'b0;
    s1_idx_nxt   = s1_idx_r;
    s2_act_nxt   = 1'b0;
    s2_gain_nxt  = v_ent.gain;
    res_smp_nxt  = res_smp_r;
    res_acc_nxt  = res_acc_r;
    v_we         = 1'b0;
    v_waddr      = s1_idx_r;
    v_wdata      = v_ent;
    v_raddr      = iss_cnt_r[VIDX_W-1:0];
    s_we         = 1'b0;
    s_waddr      = SADDR_W'(in_word.sample_address);
    s_raddr      = SADDR_W'(SUM_W'(v_ent.base) + SUM_W'(v_ent.pos));
    pos_inc      = v_ent.pos + LEN_W'(1);
    s1_act       = 1'b0;
    mac_ctl.clr  = 1'b0;
    mac_ctl.act  = s2_act_r;
    mac_ctl.gain = s2_gain_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_smp_nxt = 8'd128;
          res_acc_nxt = 1'b0;
          unique case (in_mode)
            MODE_LOAD: begin
              s_we = 1'b1;
            end
            MODE_START: begin
              if (start_ok) begin
                v_we         = 1'b1;
                v_waddr      = start_idx;
                v_wdata.base = in_word.sample_address;
                v_wdata.vend = in_word.voice_length;
                v_wdata.pos  = '0;
                v_wdata.gain = in_word.voice_volume;
                playing_nxt[start_idx] = 1'b1;
                res_acc_nxt  = 1'b1;
              end
            end
            MODE_MIX: begin
              iss_cnt_nxt = '0;
              mac_ctl.clr = 1'b1;
            end
            MODE_STOP: begin
              playing_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_MIX: begin
        // Issue one voice table read per cycle.
        if (!iss_done) begin
          s1_vld_nxt  = 1'b1;
          s1_idx_nxt  = iss_cnt_r[VIDX_W-1:0];
          iss_cnt_nxt = iss_cnt_r + VCNT_W'(1);
        end
        // Voice entry is back: fetch its sample and step its position.
        if (s1_vld_r) begin
          s1_act = playing_r[s1_idx_r] && (v_ent.pos < v_ent.vend);
          if (s1_act) begin
            v_we        = 1'b1;
            v_wdata.pos = pos_inc;
            if (pos_inc >= v_ent.vend) begin
              playing_nxt[s1_idx_r] = 1'b0;
            end
          end
        end
        s2_act_nxt = s1_act;
        if (drained) begin
          res_smp_nxt = mac_mix;
          res_acc_nxt = 1'b0;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // Output register, freed by the sink and loaded when a result is done.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_word.ready;
    out_smp_nxt   = out_smp_r;
    out_acc_nxt   = out_acc_r;
    out_mask_nxt  = out_mask_r;
    if (state_r == ST_DONE && out_free) begin
      out_valid_nxt = 1'b1;
      out_smp_nxt   = res_smp_r;
      out_acc_nxt   = res_acc_r;
      out_mask_nxt  = MASK_W'(playing_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      playing_r   <= '0;
      iss_cnt_r   <= '0;
      s1_vld_r    <= 1'b0;
      s2_act_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      playing_r   <= playing_nxt;
      iss_cnt_r   <= iss_cnt_nxt;
      s1_vld_r    <= s1_vld_nxt;
      s2_act_r    <= s2_act_nxt;
      out_valid_r <= out_valid_nxt;
    end
    s1_idx_r   <= s1_idx_nxt;
    s2_gain_r  <= s2_gain_nxt;
    res_smp_r  <= res_smp_nxt;
    res_acc_r  <= res_acc_nxt;
    out_smp_r  <= out_smp_nxt;
    out_acc_r  <= out_acc_nxt;
    out_mask_r <= out_mask_nxt;
  end

  assign out_word.valid          = out_valid_r;
  assign out_word.mix_sample     = out_smp_r;
  assign out_word.start_accepted = out_acc_r;
  assign out_word.active_mask    = out_mask_r;

  // A start that is taken leaves its voice playing.
  a_start_sets_playing: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_mode == MODE_START && start_ok |=> playing_r[$past(start_idx)])
    else $error("accepted start did not set the playing bit");

  // A result word only appears out of the done state.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result word raised outside the done state");

  // The position write-back never hits the entry being read.
  a_no_table_collision: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MIX && v_we && !iss_done |-> v_waddr != v_raddr)
    else $error("voice table write and read collide");

  // Mixing can only stop voices, never start them.
  a_mix_no_new_voice: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MIX |=> (playing_r & ~$past(playing_r)) == '0)
    else $error("a voice started during a mix");

  // The voice pipeline is empty whenever a new word can be taken.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !s1_vld_r && !s2_act_r && !mac_pend)
    else $error("voice pipeline busy while idle");

endmodule

// ===== tb/sv/mixer_word_checker.sv =====
// Checker for the PCM mixer: predicts each result word from the accepted input words and compares.
module mixer_word_checker (
  input  logic        clk,
  input  logic        rst_n,
  pcm_mix_in_if       in_mon,
  pcm_mix_out_if      out_mon,
  output int unsigned mismatch_count,
  output int unsigned pending
);
  import pcm_mix_pkg::*;

  localparam int PCM_ZERO   = 128;
  localparam int UNITY_GAIN = 255;
  localparam int REPORT_MAX = 10;

  // One input word as the block sees it.
  typedef struct packed {
    mode_t                mode;
    logic [VIDX_W-1:0]    slot;
    logic [ADDR_IN_W-1:0] addr;
    logic [BYTE_W-1:0]    data;
    logic [LEN_W-1:0]     length;
    logic [GAIN_W-1:0]    volume;
  } mixer_cmd_t;

  // One result word.
  typedef struct packed {
    logic [BYTE_W-1:0] mix_sample;
    logic              start_accepted;
    logic [MASK_W-1:0] active_mask;
  } mixer_result_t;

  // Mirror of the sample memory and the voice table.
  logic [BYTE_W-1:0]    pcm_mem   [SAMPLE_DEPTH];
  logic [ADDR_IN_W-1:0] v_base    [VOICE_COUNT];
  logic [LEN_W-1:0]     v_end     [VOICE_COUNT];
  logic [LEN_W-1:0]     v_pos     [VOICE_COUNT];
  logic [GAIN_W-1:0]    v_gain    [VOICE_COUNT];
  logic                 v_playing [VOICE_COUNT];

  // Result words still owed by the block, oldest first.
  mixer_result_t expected_words [$];

  function automatic void clear_voices();
    for (int v = 0; v < VOICE_COUNT; v++) begin
      v_base[v]    = '0;
      v_end[v]     = '0;
      v_pos[v]     = '0;
      v_gain[v]    = '0;
      v_playing[v] = 1'b0;
    end
  endfunction

  // Sum every playing voice, step it, and clamp the frame to 8 bits.
  function automatic logic [BYTE_W-1:0] mix_frame_sample();
    int          acc;
    int unsigned addr;
    int          term;
    acc = 0;
    for (int v = 0; v < VOICE_COUNT; v++) begin
      if (v_playing[v] && v_pos[v] < v_end[v]) begin
        addr = (32'(v_base[v]) + 32'(v_pos[v])) % SAMPLE_DEPTH;
        term = (int'(pcm_mem[addr]) - PCM_ZERO) * int'(v_gain[v]);
        // Signed division truncates toward zero, as the block must.
        acc += term / UNITY_GAIN;
        v_pos[v] = v_pos[v] + 1'b1;
        if (v_pos[v] >= v_end[v]) v_playing[v] = 1'b0;
      end
    end
    if (acc > 127) acc = 127;
    if (acc < -128) acc = -128;
    return BYTE_W'(acc + PCM_ZERO);
  endfunction

  // Apply one input word to the mirror and return the word the block must send.
  function automatic mixer_result_t predict_mixer_word(mixer_cmd_t w);
    mixer_result_t r;
    r.mix_sample     = BYTE_W'(PCM_ZERO);
    r.start_accepted = 1'b0;
    r.active_mask    = '0;
    case (w.mode)
      MODE_LOAD: pcm_mem[32'(w.addr) % SAMPLE_DEPTH] = w.data;
      MODE_START: begin
        if (int'(w.slot) < VOICE_COUNT && w.length != '0 && !v_playing[w.slot]) begin
          v_base[w.slot]    = w.addr;
          v_end[w.slot]     = w.length;
          v_pos[w.slot]     = '0;
          v_gain[w.slot]    = w.volume;
          v_playing[w.slot] = 1'b1;
          r.start_accepted  = 1'b1;
        end
      end
      MODE_MIX: r.mix_sample = mix_frame_sample();
      default: clear_voices();
    endcase
    for (int v = 0; v < VOICE_COUNT && v < MASK_W; v++)
      r.active_mask[v] = v_playing[v];
    return r;
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] want_v, logic [31:0] got_v);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("%0t mixer check: %s expected %0h got %0h", $realtime, what, want_v, got_v);
  endfunction

  // Watch both channels; input words first so a prediction is queued before any compare.
  always @(posedge clk) begin
    mixer_cmd_t    w;
    mixer_result_t got;
    mixer_result_t want;
    if (!rst_n) begin
      clear_voices();
      expected_words.delete();
      mismatch_count = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        w.mode   = mode_t'(in_mon.mode);
        w.slot   = in_mon.voice_id;
        w.addr   = in_mon.sample_address;
        w.data   = in_mon.sample_byte;
        w.length = in_mon.voice_length;
        w.volume = in_mon.voice_volume;
        expected_words.push_back(predict_mixer_word(w));
      end
      if (out_mon.valid && out_mon.ready) begin
        got.mix_sample     = out_mon.mix_sample;
        got.start_accepted = out_mon.start_accepted;
        got.active_mask    = out_mon.active_mask;
        if (expected_words.size() == 0) begin
          note_mismatch("word with nothing expected", '0, 32'(got));
        end else begin
          want = expected_words.pop_front();
          if (got.mix_sample !== want.mix_sample)
            note_mismatch("mix_sample", 32'(want.mix_sample), 32'(got.mix_sample));
          if (got.start_accepted !== want.start_accepted)
            note_mismatch("start_accepted", 32'(want.start_accepted),
                          32'(got.start_accepted));
          if (got.active_mask !== want.active_mask)
            note_mismatch("active_mask", 32'(want.active_mask), 32'(got.active_mask));
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

// ===== tb/sv/tb_multi_voice_pcm_mixer.sv =====
// Testbench top of the PCM mixer: clock, reset, word stimulus and the final verdict.
module tb_multi_voice_pcm_mixer;
  import pcm_mix_pkg::*;

  localparam int WORD_TARGET  = 1300;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 40;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned tx_gap_pct   = 18;
  int unsigned rx_stall_pct = 53;
  int unsigned words_sent   = 0;
  bit          hold_req     = 1'b0;

  // What the stimulus knows of the block: which bytes were loaded and where voices stand.
  // A mix never reads a byte that was not loaded.
  bit                   loaded [SAMPLE_DEPTH];
  bit [ADDR_IN_W-1:0]   sh_base [VOICE_COUNT];
  bit [LEN_W-1:0]       sh_end  [VOICE_COUNT];
  bit [LEN_W-1:0]       sh_pos  [VOICE_COUNT];
  bit                   sh_on   [VOICE_COUNT];
  logic [ADDR_IN_W-1:0] win_base;

  pcm_mix_in_if  in_ch ();
  pcm_mix_out_if out_ch ();

  multi_voice_pcm_mixer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_ch),
    .out_word (out_ch)
  );

  mixer_word_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #1000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off that fills the block up.
  initial begin
    int unsigned hold_left;
    bit          hold_served;
    hold_left   = 0;
    hold_served = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Offer one word and wait for its handshake; then track its effect on the voices.
  task automatic send_word(mode_t m, logic [VIDX_W-1:0] slot, logic [ADDR_IN_W-1:0] addr,
                           logic [BYTE_W-1:0] data, logic [LEN_W-1:0] length,
                           logic [GAIN_W-1:0] volume);
    if ($urandom_range(99) < tx_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.mode           <= m;
    in_ch.voice_id       <= slot;
    in_ch.sample_address <= addr;
    in_ch.sample_byte    <= data;
    in_ch.voice_length   <= length;
    in_ch.voice_volume   <= volume;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    case (m)
      MODE_LOAD: loaded[32'(addr) % SAMPLE_DEPTH] = 1'b1;
      MODE_START: begin
        if (!sh_on[slot] && length != '0) begin
          sh_on[slot]   = 1'b1;
          sh_base[slot] = addr;
          sh_end[slot]  = length;
          sh_pos[slot]  = '0;
        end
      end
      MODE_MIX: begin
        for (int v = 0; v < VOICE_COUNT; v++) begin
          if (sh_on[v]) begin
            sh_pos[v] = sh_pos[v] + 1'b1;
            if (sh_pos[v] >= sh_end[v]) sh_on[v] = 1'b0;
          end
        end
      end
      default: begin
        for (int v = 0; v < VOICE_COUNT; v++) sh_on[v] = 1'b0;
      end
    endcase
  endtask

  task automatic load_byte(logic [ADDR_IN_W-1:0] addr, logic [BYTE_W-1:0] data);
    send_word(MODE_LOAD, VIDX_W'($urandom), addr, data, LEN_W'($urandom), GAIN_W'($urandom));
  endtask

  task automatic launch_voice(logic [VIDX_W-1:0] slot, logic [ADDR_IN_W-1:0] base,
                              logic [LEN_W-1:0] length, logic [GAIN_W-1:0] volume);
    send_word(MODE_START, slot, base, BYTE_W'($urandom), length, volume);
  endtask

  task automatic halt_voices();
    send_word(MODE_STOP, VIDX_W'($urandom), ADDR_IN_W'($urandom), BYTE_W'($urandom),
              LEN_W'($urandom), GAIN_W'($urandom));
  endtask

  // Mix one frame, first loading any byte a playing voice is about to read.
  task automatic mix_once();
    int unsigned a;
    for (int v = 0; v < VOICE_COUNT; v++) begin
      if (sh_on[v]) begin
        a = (32'(sh_base[v]) + 32'(sh_pos[v])) % SAMPLE_DEPTH;
        if (!loaded[a]) load_byte(ADDR_IN_W'(a), BYTE_W'($urandom));
      end
    end
    send_word(MODE_MIX, VIDX_W'($urandom), ADDR_IN_W'($urandom), BYTE_W'($urandom),
              LEN_W'($urandom), GAIN_W'($urandom));
  endtask

  // Half the addresses fall in a small window so loads and voices meet.
  function automatic logic [ADDR_IN_W-1:0] pick_address();
    if ($urandom_range(1) == 1) return win_base + ADDR_IN_W'($urandom_range(255));
    return ADDR_IN_W'($urandom);
  endfunction

  function automatic logic [GAIN_W-1:0] pick_volume();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return GAIN_W'($urandom);
  endfunction

  // A short clip: load a few bytes, start a voice on them, then mix it to its end.
  task automatic play_clip();
    logic [ADDR_IN_W-1:0] base;
    logic [VIDX_W-1:0]    slot;
    int unsigned          n;
    base = pick_address();
    n    = $urandom_range(1, 12);
    slot = VIDX_W'($urandom);
    for (int t = 0; t < 4 && sh_on[slot]; t++) slot = VIDX_W'($urandom);
    for (int k = 0; k < n; k++) load_byte(base + ADDR_IN_W'(k), BYTE_W'($urandom));
    launch_voice(slot, base, LEN_W'(n), pick_volume());
    repeat (n + $urandom_range(0, 2)) mix_once();
  endtask

  // Stimulus: reset, directed words, random words, drain and verdict.
  initial begin
    int unsigned      r;
    int unsigned      r2;
    int unsigned      waited;
    logic [LEN_W-1:0] length;
    in_ch.valid          <= 1'b0;
    in_ch.mode           <= MODE_LOAD;
    in_ch.voice_id       <= '0;
    in_ch.sample_address <= '0;
    in_ch.sample_byte    <= '0;
    in_ch.voice_length   <= '0;
    in_ch.voice_volume   <= '0;
    rst_n                <= 1'b0;
    win_base = ADDR_IN_W'($urandom);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty mix, full-scale samples, address wrap, refusals and clamping.
    halt_voices();
    mix_once();
    load_byte('1, 8'h00);
    load_byte('0, 8'hFF);
    launch_voice(4'd0, '1, LEN_W'(2), '1);
    launch_voice(4'd0, 16'h0100, LEN_W'(5), 8'd9);
    launch_voice(4'd1, 16'h0200, '0, '1);
    mix_once();
    mix_once();
    launch_voice(4'd15, 16'h8000, '1, '0);
    launch_voice(4'd14, '1, LEN_W'(SAMPLE_DEPTH), 8'd1);
    mix_once();
    halt_voices();
    launch_voice(4'd2, '1, LEN_W'(1), '1);
    launch_voice(4'd3, '1, LEN_W'(1), '1);
    mix_once();
    launch_voice(4'd4, '0, LEN_W'(1), '1);
    launch_voice(4'd5, '0, LEN_W'(1), '1);
    mix_once();

    // Random: clips most often, with stray loads, starts, mixes and stops between them.
    while (words_sent < WORD_TARGET) begin
      if (words_sent >= 900) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end else if (words_sent >= 450) begin
        tx_gap_pct   = 53;
        rx_stall_pct = 18;
      end
      if (words_sent >= 950) hold_req = 1'b1;
      r = $urandom_range(99);
      if (r < 30) begin
        play_clip();
      end else if (r < 55) begin
        mix_once();
      end else if (r < 72) begin
        load_byte(pick_address(), BYTE_W'($urandom));
      end else if (r < 97) begin
        r2 = $urandom_range(99);
        if (r2 < 5) length = '0;
        else if (r2 < 8) length = LEN_W'($urandom);
        else if (r2 < 10) length = LEN_W'(SAMPLE_DEPTH);
        else length = LEN_W'($urandom_range(1, 40));
        launch_voice(VIDX_W'($urandom), pick_address(), length, pick_volume());
      end else begin
        halt_voices();
      end
    end
    in_ch.valid <= 1'b0;

    // Drain: wait for every owed word, then a little longer for strays.
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== multi_voice_pcm_mixer.f =====
design/pcm_mix_pkg.sv
design/pcm_mix_if.sv
design/pcm_mix_ram.sv
design/pcm_mix_acc.sv
design/multi_voice_pcm_mixer.sv
tb/sv/mixer_word_checker.sv
tb/sv/tb_multi_voice_pcm_mixer.sv
